// ===== sv/face_uv_linear_subdivide_defines.svh =====
// ----------------------------------------------------------------------------
// face uv linear subdivide: assertion macros
// concurrent checks on clk, disabled while rst is high; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef FACE_UV_LINEAR_SUBDIVIDE_DEFINES_SVH
`define FACE_UV_LINEAR_SUBDIVIDE_DEFINES_SVH
`ifndef SYNTHESIS
// property that holds at every edge
`define FULS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition now implies a condition at the next edge
`define FULS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define FULS_ASSERT(lbl, prop, msg)
`define FULS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== sv/fuls_pkg.sv =====
// ----------------------------------------------------------------------------
// fuls_pkg
// shared types and side codes
// ----------------------------------------------------------------------------
package fuls_pkg;

  typedef logic [1:0] side_t;

  // last side of a face
  localparam side_t TRI_LAST_SIDE  = 2'd2;
  localparam side_t QUAD_LAST_SIDE = 2'd3;

  typedef struct packed {
    side_t index;
    logic  last;
  } sub_tag_t;

endpackage

// ===== sv/face_uv_linear_subdivide.sv =====
// ----------------------------------------------------------------------------
// face_uv_linear_subdivide
// linear subdivision of one face's uv corners into one sub-face per side
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat is a face, four signed q4.12 (u,v) corners plus
//   is_quad; a triangle has three sides and corner 3 is dropped
//   output channel: one beat per sub-face, side j in order, sub_index = j,
//   last_sub high on the final side; corners are the midpoint toward the
//   previous corner, corner j, the midpoint toward the next corner, the centre
//   path: from the input register a face passes the sum register, divide
//   register and face holder; its sub-faces leave through the output register
//   throughput: one sub-face per cycle while out_ready is high; the next
//   face is loaded as the last side of the current one is sent
//   the centre of a triangle needs a divide by three, done in one stage as a
//   multiply by a fixed reciprocal
//   reset: all pipeline stages and the output register empty, no beat pending
//   stall: a held output beat stalls the emitter, which holds its face; the
//   stages in front keep filling until full, then in_ready drops
// ----------------------------------------------------------------------------
module face_uv_linear_subdivide import fuls_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_u0,
  input  logic signed [COORD_BITS-1:0] in_v0,
  input  logic signed [COORD_BITS-1:0] in_u1,
  input  logic signed [COORD_BITS-1:0] in_v1,
  input  logic signed [COORD_BITS-1:0] in_u2,
  input  logic signed [COORD_BITS-1:0] in_v2,
  input  logic signed [COORD_BITS-1:0] in_u3,
  input  logic signed [COORD_BITS-1:0] in_v3,
  input  logic                         is_quad,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_u0,
  output logic signed [COORD_BITS-1:0] out_v0,
  output logic signed [COORD_BITS-1:0] out_u1,
  output logic signed [COORD_BITS-1:0] out_v1,
  output logic signed [COORD_BITS-1:0] out_u2,
  output logic signed [COORD_BITS-1:0] out_v2,
  output logic signed [COORD_BITS-1:0] out_u3,
  output logic signed [COORD_BITS-1:0] out_v3,
  output logic [1:0]                   sub_index,
  output logic                         last_sub
);

  localparam int W  = COORD_BITS;
  // dividend width: sum of three corners, offset to stay positive
  localparam int TW = W + 2;
  // carried along: quad flag, quad centre u and v, eight corner coordinates
  localparam int PW = 10 * W + 1;

  logic signed [W-1:0] face_u [4];
  logic signed [W-1:0] face_v [4];

  // handshake and data between the sum register and the divider
  logic          fr_valid;
  logic          fr_ready;
  logic [TW-1:0] fr_tu;
  logic [TW-1:0] fr_tv;
  logic [PW-1:0] fr_pass;

  // handshake and data between the divider and the emitter
  logic          dv_valid;
  logic          dv_ready;
  logic [PW-1:0] dv_pass;

  logic signed [W-1:0] em_u [4];
  logic signed [W-1:0] em_v [4];
  logic                em_quad;
  logic [W-1:0]        tri_u;
  logic [W-1:0]        tri_v;
  logic signed [W-1:0] cen_u;
  logic signed [W-1:0] cen_v;

  logic signed [W-1:0] res_u [4];
  logic signed [W-1:0] res_v [4];
  sub_tag_t            res_tag;

  assign face_u = '{in_u0, in_u1, in_u2, in_u3};
  assign face_v = '{in_v0, in_v1, in_v2, in_v3};

  // input register, then corner sums with the triangle offset
  fuls_front #(
    .W (W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_u      (face_u),
    .in_v      (face_v),
    .in_quad   (is_quad),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_tu    (fr_tu),
    .out_tv    (fr_tv),
    .out_pass  (fr_pass)
  );

  // divide by three through a multiply by the reciprocal
  fuls_div_stage #(
    .TW (TW),
    .PW (PW)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fr_valid),
    .in_ready   (fr_ready),
    .in_work_u  (fr_tu),
    .in_work_v  (fr_tv),
    .in_pass    (fr_pass),
    .out_valid  (dv_valid),
    .out_ready  (dv_ready),
    .out_quo_u  (tri_u),
    .out_quo_v  (tri_v),
    .out_pass   (dv_pass)
  );

  // unpack the carried face
  for (genvar k = 0; k < 4; k++) begin : g_unpack
    assign em_v[k] = dv_pass[k*W +: W];
    assign em_u[k] = dv_pass[(4 + k)*W +: W];
  end
  assign em_quad = dv_pass[10*W];

  // the quotient carries the offset 2^(W-1): removing it flips the top bit
  assign cen_u = em_quad ? dv_pass[9*W +: W] : {~tri_u[W-1], tri_u[W-2:0]};
  assign cen_v = em_quad ? dv_pass[8*W +: W] : {~tri_v[W-1], tri_v[W-2:0]};

  // face holder and output register
  fuls_emit #(
    .W (W)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_u      (em_u),
    .in_v      (em_v),
    .in_quad   (em_quad),
    .in_du     (cen_u),
    .in_dv     (cen_v),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_u     (res_u),
    .out_v     (res_v),
    .out_tag   (res_tag)
  );

  assign out_u0    = res_u[0];
  assign out_v0    = res_v[0];
  assign out_u1    = res_u[1];
  assign out_v1    = res_v[1];
  assign out_u2    = res_u[2];
  assign out_v2    = res_v[2];
  assign out_u3    = res_u[3];
  assign out_v3    = res_v[3];
  assign sub_index = res_tag.index;
  assign last_sub  = res_tag.last;

endmodule

// ===== sv/fuls_front.sv =====
// ----------------------------------------------------------------------------
// fuls_front
// input register and corner-sum register; forms the dividend for the centre
// ----------------------------------------------------------------------------
module fuls_front #(
  parameter int W = 16,
  localparam int TW = W + 2,
  localparam int PW = 10 * W + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] in_u [4],
  input  logic signed [W-1:0] in_v [4],
  input  logic                in_quad,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TW-1:0]       out_tu,
  output logic [TW-1:0]       out_tv,
  output logic [PW-1:0]       out_pass
);

  // sum + 1 + 3 * 2^(W-1): positive, and a multiple of three away from sum + 1
  localparam logic [TW-1:0] TRI_OFS = {2'b01, 1'b1, {(W - 2){1'b0}}, 1'b1};
  localparam logic [TW-1:0] QUAD_RND = TW'(2);

  logic                r_valid;
  logic signed [W-1:0] r_u [4];
  logic signed [W-1:0] r_v [4];
  logic                r_quad;
  logic                r_ready;
  logic                s_ready;

  logic signed [TW-1:0] su;
  logic signed [TW-1:0] sv;
  logic [TW-1:0]        su_rnd;
  logic [TW-1:0]        sv_rnd;

  assign s_ready  = !out_valid || out_ready;
  assign r_ready  = !r_valid || s_ready;
  assign in_ready = r_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (r_ready) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && r_ready) begin
      r_u    <= in_u;
      r_v    <= in_v;
      r_quad <= in_quad;
    end
  end

  always_comb begin
    su = TW'(r_u[0]) + TW'(r_u[1]) + TW'(r_u[2]) + (r_quad ? TW'(r_u[3]) : '0);
    sv = TW'(r_v[0]) + TW'(r_v[1]) + TW'(r_v[2]) + (r_quad ? TW'(r_v[3]) : '0);
    su_rnd = su + QUAD_RND;
    sv_rnd = sv + QUAD_RND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_ready) begin
      out_valid <= r_valid;
    end
  end

  // quad centre is (sum + 2) >>> 2, carried alongside the corners
  always_ff @(posedge clk) begin
    if (r_valid && s_ready) begin
      out_tu   <= su + TRI_OFS;
      out_tv   <= sv + TRI_OFS;
      out_pass <= {r_quad, su_rnd[TW-1:2], sv_rnd[TW-1:2],
                   r_u[3], r_u[2], r_u[1], r_u[0],
                   r_v[3], r_v[2], r_v[1], r_v[0]};
    end
  end

endmodule

// ===== sv/fuls_div_stage.sv =====
// ----------------------------------------------------------------------------
// fuls_div_stage
// one pipeline stage dividing the u and v dividends by three
// ----------------------------------------------------------------------------
module fuls_div_stage #(
  parameter int TW = 18,
  parameter int PW = 161,
  localparam int QW  = TW - 2,
  localparam int MW  = TW + 1,
  localparam int PRW = 2 * TW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [TW-1:0] in_work_u,
  input  logic [TW-1:0] in_work_v,
  input  logic [PW-1:0] in_pass,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_quo_u,
  output logic [QW-1:0] out_quo_v,
  output logic [PW-1:0] out_pass
);

  // ceil(2^(TW+2) / 3): exact floor quotient for every dividend below 2^(TW+1)
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << (TW + 2)) + 64'd2) / 64'd3);

  logic [PRW-1:0] prod_u;
  logic [PRW-1:0] prod_v;

  assign in_ready = !out_valid || out_ready;

  // quotient is the product shifted down by TW + 2, it fits in QW bits
  always_comb begin
    prod_u = PRW'(in_work_u) * PRW'(RECIP);
    prod_v = PRW'(in_work_v) * PRW'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_quo_u <= prod_u[PRW-1 -: QW];
      out_quo_v <= prod_v[PRW-1 -: QW];
      out_pass  <= in_pass;
    end
  end

endmodule

// ===== sv/fuls_emit.sv =====
// ----------------------------------------------------------------------------
// fuls_emit
// holds one face and sends its sub-faces, one per beat, through an output reg
// ----------------------------------------------------------------------------
`include "face_uv_linear_subdivide_defines.svh"

module fuls_emit import fuls_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] in_u [4],
  input  logic signed [W-1:0] in_v [4],
  input  logic                in_quad,
  input  logic signed [W-1:0] in_du,
  input  logic signed [W-1:0] in_dv,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_u [4],
  output logic signed [W-1:0] out_v [4],
  output sub_tag_t            out_tag
);

  logic                face_full;
  logic                face_quad;
  logic signed [W-1:0] fu [4];
  logic signed [W-1:0] fv [4];
  logic signed [W-1:0] du;
  logic signed [W-1:0] dv;
  side_t               emit_index;
  logic                out_quad;

  side_t               side_last;
  logic                is_last;
  logic                load;
  logic signed [W-1:0] prev_u;
  logic signed [W-1:0] prev_v;

  function automatic logic signed [W-1:0] mid(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = (W + 1)'(a) + (W + 1)'(b);
    return s[W:1];
  endfunction

  // slot 0 is always corner j: slot 1 is next, the last used slot is previous
  always_comb begin
    side_last = face_quad ? QUAD_LAST_SIDE : TRI_LAST_SIDE;
    is_last   = (emit_index == side_last);
    load      = face_full && (!out_valid || out_ready);
    prev_u    = face_quad ? fu[3] : fu[2];
    prev_v    = face_quad ? fv[3] : fv[2];
    in_ready  = !face_full || (load && is_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_full  <= 1'b0;
      emit_index <= '0;
    end else begin
      if (in_valid && in_ready) begin
        face_full <= 1'b1;
      end else if (load && is_last) begin
        face_full <= 1'b0;
      end
      if (load) begin
        emit_index <= is_last ? '0 : side_t'(emit_index + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fu        <= in_u;
      fv        <= in_v;
      face_quad <= in_quad;
      du        <= in_du;
      dv        <= in_dv;
    end else if (load) begin
      fu[0] <= fu[1];
      fu[1] <= fu[2];
      fu[2] <= face_quad ? fu[3] : fu[0];
      fu[3] <= fu[0];
      fv[0] <= fv[1];
      fv[1] <= fv[2];
      fv[2] <= face_quad ? fv[3] : fv[0];
      fv[3] <= fv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_u[0]      <= mid(fu[0], prev_u);
      out_v[0]      <= mid(fv[0], prev_v);
      out_u[1]      <= fu[0];
      out_v[1]      <= fv[0];
      out_u[2]      <= mid(fu[0], fu[1]);
      out_v[2]      <= mid(fv[0], fv[1]);
      out_u[3]      <= du;
      out_v[3]      <= dv;
      out_tag.index <= emit_index;
      out_tag.last  <= is_last;
      out_quad      <= face_quad;
    end
  end

  `FULS_ASSERT(a_last_on_final_side, !out_valid || (out_tag.last == (out_tag.index == (out_quad ? QUAD_LAST_SIDE : TRI_LAST_SIDE))), "last flag does not match the final side")
  `FULS_ASSERT_NEXT(a_sides_in_order, out_valid && out_ready && !out_tag.last, out_valid && (out_tag.index == side_t'($past(out_tag.index) + 2'd1)), "sub-face missing or out of order")
  `FULS_ASSERT_NEXT(a_face_starts_at_zero, out_valid && out_ready && out_tag.last, !out_valid || (out_tag.index == '0), "new face does not start at side zero")
  `FULS_ASSERT(a_no_face_while_busy, !(face_full && !load && in_ready), "face accepted over a held face")

endmodule
